/* rtl/core/rgbenc_pkg.sv */
// shared types and constants for the parallel rgb led chain encoder
// no dependencies; imported by parallel_rgb_led_chain_encoder
package rgbenc_pkg;

    localparam int CHAIN_COUNT_DEF  = 8;
    localparam int CHAIN_MAX        = 8;
    localparam int BITS_PER_BYTE    = 8;

    localparam logic [15:0] RESET_HOLD_RST = 16'(80 * 16);
    localparam logic [7:0]  LEAD_HOLD_RST  = 8'd2;
    localparam logic [7:0]  DATA_HOLD_RST  = 8'd5;
    localparam logic [7:0]  TAIL_HOLD_RST  = 8'd10;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_RESET_HOLD = 2'd0,
        REG_LEAD_HOLD  = 2'd1,
        REG_DATA_HOLD  = 2'd2,
        REG_TAIL_HOLD  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CHAIN_MAX*BITS_PER_BYTE-1:0] chain_bytes;
        logic                               frame_start;
    } t_in_item;

    typedef struct packed {
        logic [CHAIN_MAX-1:0] pin_levels;
        logic [15:0]          hold_cycles;
        logic                 last_phase;
    } t_out_item;

endpackage

/* rtl/core/parallel_rgb_led_chain_encoder.sv */
// parallel rgb led chain encoder: top level, phase sequencer and register file
// depends on rgbenc_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in_data): one item carries one
//   colour byte per chain and a frame_start flag
//   output channel (o_out_valid / i_out_ready / o_out_data): one item per timed
//   pin phase; for each bit-plane (msb first) a lead phase with all used pins
//   high, a data phase showing the plane and a tail phase with all pins low;
//   a frame_start item is preceded by one all-low reset phase
//   apb port: reset_hold at 0x0, lead_high_hold at 0x4, data_hold at 0x8,
//   tail_low_hold at 0xc; pready always high, reads return the register
// an accepted item is held in the item register and sequencer, and its first
//   phase then moves from there into the output register
// each item gives eight bit-planes of three phases, one more with frame_start;
//   the single output register takes one phase per cycle while the receiver keeps up
// the next item is accepted in the cycle the current item's final phase is
//   loaded, so phases stream with no gap while the receiver keeps up
// when the receiver stalls the output register holds and the sequencer waits
// reset restores the default hold times and empties both stages
module parallel_rgb_led_chain_encoder
    import rgbenc_pkg::*;
#(
    parameter int CHAIN_COUNT = CHAIN_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // pins of chains that exist; the rest stay low
    localparam logic [CHAIN_MAX-1:0] PIN_MASK = CHAIN_MAX'((1 << CHAIN_COUNT) - 1);

    typedef enum logic [1:0] {
        PH_RESET,
        PH_LEAD,
        PH_DATA,
        PH_TAIL
    } t_phase;

    // hold-time registers
    logic [15:0] r_reset_hold;
    logic [7:0]  r_lead_hold;
    logic [7:0]  r_data_hold;
    logic [7:0]  r_tail_hold;

    // item register and sequencer
    logic                               r_busy;
    logic [CHAIN_MAX*BITS_PER_BYTE-1:0] r_bytes;
    t_phase                             r_phase;
    logic [2:0]                         r_bit;

    // output register
    logic       r_out_valid;
    t_out_item  r_out;

    logic       advance;
    logic       final_phase;
    logic       accept;
    logic       cfg_wr;
    t_reg_idx   reg_idx;
    logic [CHAIN_MAX-1:0] plane;
    t_out_item  n_out;
    t_phase     n_phase;
    logic [2:0] n_bit;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // register read-back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_RESET_HOLD: prdata = PDATA_W'(r_reset_hold);
            REG_LEAD_HOLD:  prdata = PDATA_W'(r_lead_hold);
            REG_DATA_HOLD:  prdata = PDATA_W'(r_data_hold);
            REG_TAIL_HOLD:  prdata = PDATA_W'(r_tail_hold);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_hold <= RESET_HOLD_RST;
            r_lead_hold  <= LEAD_HOLD_RST;
            r_data_hold  <= DATA_HOLD_RST;
            r_tail_hold  <= TAIL_HOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RESET_HOLD: r_reset_hold <= pwdata[15:0];
                REG_LEAD_HOLD:  r_lead_hold  <= pwdata[7:0];
                REG_DATA_HOLD:  r_data_hold  <= pwdata[7:0];
                REG_TAIL_HOLD:  r_tail_hold  <= pwdata[7:0];
            endcase
        end
    end

    // a phase moves into the output register when it is empty or being drained
    assign advance     = r_busy && (!r_out_valid || i_out_ready);
    assign final_phase = (r_phase == PH_TAIL) && (r_bit == 3'd7);
    assign o_in_ready  = !r_busy || (advance && final_phase);
    assign accept      = i_in_valid && o_in_ready;

    // transpose: bit c of the plane is the current bit of chain c's byte
    always_comb begin
        logic [BITS_PER_BYTE-1:0] byte_c;
        plane = '0;
        for (int c = 0; c < CHAIN_COUNT; c++) begin
            byte_c   = r_bytes[c*BITS_PER_BYTE +: BITS_PER_BYTE];
            plane[c] = byte_c[~r_bit];
        end
    end

    // phase payload and next sequencer position
    always_comb begin
        n_out   = '0;
        n_phase = r_phase;
        n_bit   = r_bit;
        unique case (r_phase)
            PH_RESET: begin
                n_out.hold_cycles = r_reset_hold;
                n_phase           = PH_LEAD;
            end
            PH_LEAD: begin
                n_out.pin_levels  = PIN_MASK;
                n_out.hold_cycles = 16'(r_lead_hold);
                n_phase           = PH_DATA;
            end
            PH_DATA: begin
                n_out.pin_levels  = plane & PIN_MASK;
                n_out.hold_cycles = 16'(r_data_hold);
                n_phase           = PH_TAIL;
            end
            PH_TAIL: begin
                n_out.hold_cycles = 16'(r_tail_hold);
                n_out.last_phase  = final_phase;
                n_phase           = PH_LEAD;
                n_bit             = r_bit + 3'd1;
            end
            default: begin
                n_phase = PH_LEAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_LEAD;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // sequencer: a new item may load in the cycle the last phase leaves
            if (accept) begin
                r_busy  <= 1'b1;
                r_phase <= i_in_data.frame_start ? PH_RESET : PH_LEAD;
                r_bit   <= '0;
            end else if (advance) begin
                if (final_phase) begin
                    r_busy <= 1'b0;
                end
                r_phase <= n_phase;
                r_bit   <= n_bit;
            end
        end
    end

    // item payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes <= i_in_data.chain_bytes;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
